// File: src/qst_pkg.sv
// Package for the quaternion similarity transform: widths, register codes and item types.
package qst_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int QUAT_WIDTH   = 18;
    localparam int SCALE_WIDTH  = 20;
    localparam int SCALE_FRAC   = 16;
    localparam int SHIFT_WIDTH  = 24;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 24;
    // rotation matrix entries reach 2^36 in magnitude
    localparam int MAT_WIDTH    = 38;
    localparam int MLO_WIDTH    = 19;
    // quaternion norm, at most 2^36
    localparam int NORM_WIDTH   = 37;
    // rotated coordinate before scaling
    localparam int QUO_WIDTH    = COORD_WIDTH + 2;
    // start to strobe, in clock edges
    localparam int LATENCY      = QUO_WIDTH + 6;
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SCALE   = 3'd4,
        REG_SHIFT_X = 3'd5,
        REG_SHIFT_Y = 3'd6,
        REG_SHIFT_Z = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] world_x;
        logic signed [COORD_WIDTH-1:0] world_y;
        logic signed [COORD_WIDTH-1:0] world_z;
        logic                          passed_through;
        logic                          overflow_flag;
        logic                          zero_norm_flag;
    } t_out_item;

endpackage

// File: src/quaternion_similarity_transform.sv
// Quaternion similarity transform: pipelined rotate/scale/shift, a point per cycle unless busy.

// One point is taken per clock while busy is low. Its result is on o_result with o_strobe
// for one cycle, once the point has passed the input, product, sum and divider registers
// and the scale and output registers. The receiver cannot stall the pipe. The depth is set
// by the restoring divider that divides the rotated vector by |q|^2, one quotient bit per
// stage. After reset and after every configuration write busy stays high while the
// rotation matrix is rebuilt.
// Configuration may only be written when no item is in flight.
module quaternion_similarity_transform
    import qst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  t_in_item                  i_item,
    output logic                      o_strobe,
    output t_out_item                 o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int QW  = QUO_WIDTH;
    localparam int RW  = QW + MAT_WIDTH;
    localparam int SW  = MAT_WIDTH + CW + 2;
    localparam int PLW = MLO_WIDTH + 1 + CW;
    localparam int PHW = MAT_WIDTH - MLO_WIDTH + CW;
    localparam int PW  = QW + SCALE_WIDTH + 1;
    localparam int TW  = ((QW + 5 > SHIFT_WIDTH) ? QW + 5 : SHIFT_WIDTH) + 1;
    localparam int VP  = QW + 4;
    localparam int VL  = QW + 5;
    localparam int ROUND_HALF = 1 << (SCALE_FRAC - 1);
    localparam logic signed [TW-1:0] SAT_HI = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

    // configuration
    logic signed [QUAT_WIDTH-1:0]  r_rot [4];
    logic        [SCALE_WIDTH-1:0] r_scale;
    logic signed [SHIFT_WIDTH-1:0] r_shift [3];
    logic        [1:0]             r_settle;

    // matrix build
    logic signed [2*QUAT_WIDTH-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic signed [MAT_WIDTH-1:0]    r_m [3][3];
    logic        [NORM_WIDTH-1:0]   r_n;

    // item pipe
    logic                        r_vld [0:VL];
    logic [2:0][CW-1:0]          r_vpipe [0:VP];
    logic signed [PLW-1:0]       r_plo [3][3];
    logic signed [PHW-1:0]       r_phi [3][3];
    logic signed [SW-1:0]        r_sum [3];
    logic [RW-1:0]               r_rem [3][0:QW];
    logic [QW-1:0]               r_quo [3][0:QW];
    logic signed [PW-1:0]        r_prod [3];
    t_out_item                   r_out;
    t_out_item                   n_out;
    logic signed [SW-1:0]        n_sum [3];

    assign busy        = (r_settle != 2'd0);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_vld[VL];
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= QUAT_WIDTH'(1 << SCALE_FRAC);
            r_rot[1]   <= '0;
            r_rot[2]   <= '0;
            r_rot[3]   <= '0;
            r_scale    <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
            r_settle   <= SETTLE_CYCLES;
        end else if (i_cfg_valid) begin
            r_settle <= SETTLE_CYCLES;
            unique case (t_cfg_idx'(i_cfg_index))
                REG_ROT_W:   r_rot[0]   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_ROT_X:   r_rot[1]   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_ROT_Y:   r_rot[2]   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_ROT_Z:   r_rot[3]   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_SCALE:   r_scale    <= i_cfg_data[SCALE_WIDTH-1:0];
                REG_SHIFT_X: r_shift[0] <= i_cfg_data[SHIFT_WIDTH-1:0];
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data[SHIFT_WIDTH-1:0];
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data[SHIFT_WIDTH-1:0];
                default:     r_scale    <= r_scale;
            endcase
        end else if (busy) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // matrix of q v q*, the rotation times |q|^2, rebuilt continuously from the registers
    always_ff @(posedge i_clk) begin
        r_ww <= r_rot[0] * r_rot[0];
        r_xx <= r_rot[1] * r_rot[1];
        r_yy <= r_rot[2] * r_rot[2];
        r_zz <= r_rot[3] * r_rot[3];
        r_xy <= r_rot[1] * r_rot[2];
        r_wz <= r_rot[0] * r_rot[3];
        r_xz <= r_rot[1] * r_rot[3];
        r_wy <= r_rot[0] * r_rot[2];
        r_yz <= r_rot[2] * r_rot[3];
        r_wx <= r_rot[0] * r_rot[1];

        r_m[0][0] <= MAT_WIDTH'(r_ww) + MAT_WIDTH'(r_xx) - MAT_WIDTH'(r_yy) - MAT_WIDTH'(r_zz);
        r_m[0][1] <= (MAT_WIDTH'(r_xy) - MAT_WIDTH'(r_wz)) <<< 1;
        r_m[0][2] <= (MAT_WIDTH'(r_xz) + MAT_WIDTH'(r_wy)) <<< 1;
        r_m[1][0] <= (MAT_WIDTH'(r_xy) + MAT_WIDTH'(r_wz)) <<< 1;
        r_m[1][1] <= MAT_WIDTH'(r_ww) - MAT_WIDTH'(r_xx) + MAT_WIDTH'(r_yy) - MAT_WIDTH'(r_zz);
        r_m[1][2] <= (MAT_WIDTH'(r_yz) - MAT_WIDTH'(r_wx)) <<< 1;
        r_m[2][0] <= (MAT_WIDTH'(r_xz) - MAT_WIDTH'(r_wy)) <<< 1;
        r_m[2][1] <= (MAT_WIDTH'(r_yz) + MAT_WIDTH'(r_wx)) <<< 1;
        r_m[2][2] <= MAT_WIDTH'(r_ww) - MAT_WIDTH'(r_xx) - MAT_WIDTH'(r_yy) + MAT_WIDTH'(r_zz);
        r_n       <= NORM_WIDTH'(r_ww) + NORM_WIDTH'(r_xx) + NORM_WIDTH'(r_yy)
                   + NORM_WIDTH'(r_zz);
    end

    // valid bits and the point itself travel alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= VL; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k <= VL; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vpipe[0] <= {i_item.point_z, i_item.point_y, i_item.point_x};
        for (int k = 1; k <= VP; k++) begin
            r_vpipe[k] <= r_vpipe[k-1];
        end
    end

    // matrix-vector products, each entry split in two halves to keep multipliers narrow
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_plo[i][j] <= $signed({1'b0, r_m[i][j][MLO_WIDTH-1:0]})
                             * $signed(r_vpipe[0][j]);
                r_phi[i][j] <= $signed(r_m[i][j][MAT_WIDTH-1:MLO_WIDTH])
                             * $signed(r_vpipe[0][j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = '0;
            for (int j = 0; j < 3; j++) begin
                n_sum[i] = n_sum[i] + (SW'(r_phi[i][j]) <<< MLO_WIDTH) + SW'(r_plo[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sum[i] <= n_sum[i];
        end
    end

    // round(S/n) = floor((2S + n) / 2n); offset by 2^(QW-1) quotients to stay unsigned
    for (genvar i = 0; i < 3; i++) begin : g_div_init
        always_ff @(posedge i_clk) begin
            r_rem[i][0] <= (RW'(r_sum[i]) << 1) + RW'(r_n) + (RW'(r_n) << QW);
            r_quo[i][0] <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int K = QW - 1 - s;
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [RW-1:0] dsh;
            assign dsh = RW'(r_n) << (K + 1);
            always_ff @(posedge i_clk) begin
                if (r_rem[i][s] >= dsh) begin
                    r_rem[i][s+1] <= r_rem[i][s] - dsh;
                    r_quo[i][s+1] <= r_quo[i][s] | (QW'(1) << K);
                end else begin
                    r_rem[i][s+1] <= r_rem[i][s];
                    r_quo[i][s+1] <= r_quo[i][s];
                end
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_scale
        logic signed [QW-1:0] quo;
        assign quo = $signed(r_quo[i][QW] ^ {1'b1, {(QW-1){1'b0}}});
        always_ff @(posedge i_clk) begin
            r_prod[i] <= quo * $signed({1'b0, r_scale}) + PW'(ROUND_HALF);
        end
    end

    always_comb begin
        logic signed [TW-1:0] t [3];
        logic [2:0]           sat;
        logic [2:0][CW-1:0]   res;
        for (int i = 0; i < 3; i++) begin
            if (r_n == '0) begin
                t[i] = TW'(r_shift[i]);
            end else begin
                t[i] = TW'(r_prod[i] >>> SCALE_FRAC) + TW'(r_shift[i]);
            end
            sat[i] = 1'b0;
            if (t[i] > SAT_HI) begin
                res[i] = SAT_HI[CW-1:0];
                sat[i] = 1'b1;
            end else if (t[i] < SAT_LO) begin
                res[i] = SAT_LO[CW-1:0];
                sat[i] = 1'b1;
            end else begin
                res[i] = t[i][CW-1:0];
            end
        end
        if (r_scale == '0) begin
            n_out.world_x        = r_vpipe[VP][0];
            n_out.world_y        = r_vpipe[VP][1];
            n_out.world_z        = r_vpipe[VP][2];
            n_out.passed_through = 1'b1;
            n_out.overflow_flag  = 1'b0;
            n_out.zero_norm_flag = 1'b0;
        end else begin
            n_out.world_x        = res[0];
            n_out.world_y        = res[1];
            n_out.world_z        = res[2];
            n_out.passed_through = 1'b0;
            n_out.overflow_flag  = |sat;
            n_out.zero_norm_flag = (r_n == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// File: src/qst_checker.sv
// Port-level checks for the quaternion similarity transform, bound to the top level.
module qst_checker
    import qst_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_strobe,
    input t_out_item                 o_result,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready
);

    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_strobe)
        else $error("accepted item produced no result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    a_cfg_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> busy)
        else $error("not busy after configuration write");

    a_pass_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.passed_through |->
            !o_result.overflow_flag && !o_result.zero_norm_flag)
        else $error("flags set on pass-through item");

endmodule

bind quaternion_similarity_transform qst_checker u_qst_checker (.*);

// File: bench/quaternion_similarity_transform_tb.sv
// Self-checking bench for the quaternion similarity transform: random and corner points, several calibrations.
module quaternion_similarity_transform_tb;
    import qst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected world points, checked in order of arrival
    class world_point_board;
        t_out_item pending[$];
        int errors;
        int checked;

        // configuration copy
        logic [QUAT_WIDTH-1:0]  rot[4];
        logic [SCALE_WIDTH-1:0] scale;
        logic [SHIFT_WIDTH-1:0] shift[3];

        function new();
            errors = 0;
            checked = 0;
            rot[0] = 18'd65536;
            rot[1] = '0;
            rot[2] = '0;
            rot[3] = '0;
            scale = '0;
            shift[0] = '0;
            shift[1] = '0;
            shift[2] = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                REG_ROT_W, REG_ROT_X, REG_ROT_Y, REG_ROT_Z: rot[idx] = data[QUAT_WIDTH-1:0];
                REG_SCALE: scale = data[SCALE_WIDTH-1:0];
                default: shift[idx - REG_SHIFT_X] = data[SHIFT_WIDTH-1:0];
            endcase
        endfunction

        function longint fdiv(longint a, longint d, output longint rem);
            longint q;
            q = a / d;
            rem = a % d;
            if (rem < 0) begin
                q -= 1;
                rem += d;
            end
            return q;
        endfunction

        function longint clamp(longint v, inout bit ovf);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                ovf = 1;
                return hi;
            end
            if (v < lo) begin
                ovf = 1;
                return lo;
            end
            return v;
        endfunction

        function void note_point(t_in_item p);
            t_out_item e;
            longint v[3], sh[3], res[3], m[3][3], vh[3], vl[3];
            longint w, x, y, z, ww, xx, yy, zz, n, mh, ml, r, qh, qt, q, pr;
            bit ovf;
            ovf = 0;
            v[0] = p.point_x;
            v[1] = p.point_y;
            v[2] = p.point_z;
            for (int i = 0; i < 3; i++) sh[i] = $signed(shift[i]);
            e = '0;
            if (scale == 0) begin
                e.passed_through = 1;
                for (int i = 0; i < 3; i++) res[i] = v[i];
            end else begin
                w = $signed(rot[0]);
                x = $signed(rot[1]);
                y = $signed(rot[2]);
                z = $signed(rot[3]);
                ww = w * w; xx = x * x; yy = y * y; zz = z * z;
                n = ww + xx + yy + zz;
                if (n == 0) begin
                    e.zero_norm_flag = 1;
                    for (int i = 0; i < 3; i++) res[i] = clamp(sh[i], ovf);
                end else begin
                    m[0][0] = ww + xx - yy - zz;
                    m[0][1] = 2 * (x * y - w * z);
                    m[0][2] = 2 * (x * z + w * y);
                    m[1][0] = 2 * (x * y + w * z);
                    m[1][1] = ww - xx + yy - zz;
                    m[1][2] = 2 * (y * z - w * x);
                    m[2][0] = 2 * (x * z - w * y);
                    m[2][1] = 2 * (y * z + w * x);
                    m[2][2] = ww - xx - yy + zz;
                    for (int j = 0; j < 3; j++) begin
                        vh[j] = fdiv(v[j], 65536, r);
                        vl[j] = r;
                    end
                    for (int i = 0; i < 3; i++) begin
                        mh = 0;
                        ml = 0;
                        for (int j = 0; j < 3; j++) begin
                            mh += m[i][j] * vh[j];
                            ml += m[i][j] * vl[j];
                        end
                        qh = fdiv(mh, n, r);
                        qt = fdiv(r * 65536 + ml, n, r);
                        q = qh * 65536 + qt;
                        if (2 * r >= n) q += 1;
                        pr = q * longint'(scale) + 32768;
                        q = fdiv(pr, 65536, r);
                        res[i] = clamp(q + sh[i], ovf);
                    end
                end
            end
            e.world_x = res[0][COORD_WIDTH-1:0];
            e.world_y = res[1][COORD_WIDTH-1:0];
            e.world_z = res[2][COORD_WIDTH-1:0];
            e.overflow_flag = ovf;
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.world_x !== e.world_x) begin
                $error("world_x exp %0d got %0d", e.world_x, got.world_x);
                errors++;
            end
            if (got.world_y !== e.world_y) begin
                $error("world_y exp %0d got %0d", e.world_y, got.world_y);
                errors++;
            end
            if (got.world_z !== e.world_z) begin
                $error("world_z exp %0d got %0d", e.world_z, got.world_z);
                errors++;
            end
            if (got.passed_through !== e.passed_through) begin
                $error("passed_through exp %0b got %0b", e.passed_through, got.passed_through);
                errors++;
            end
            if (got.overflow_flag !== e.overflow_flag) begin
                $error("overflow_flag exp %0b got %0b", e.overflow_flag, got.overflow_flag);
                errors++;
            end
            if (got.zero_norm_flag !== e.zero_norm_flag) begin
                $error("zero_norm_flag exp %0b got %0b", e.zero_norm_flag, got.zero_norm_flag);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    t_in_item                  i_item;
    logic                      o_strobe;
    t_out_item                 o_result;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data;

    world_point_board board;
    int idle_pct;
    int points_sent;
    int cfg_writes;

    quaternion_similarity_transform dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) board.check_result(o_result);
    end

    // one point, with a random gap before it; start is left high for the next one
    task automatic send_point(t_in_item p);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_item <= p;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_point(p);
        points_sent++;
        @(negedge i_clk);
    endtask

    // block is idle only once all results are back and the pipe has drained
    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // valid is left high for the next write
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.set_reg(idx, data);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic set_calib(logic [QUAT_WIDTH-1:0] w, logic [QUAT_WIDTH-1:0] x,
                             logic [QUAT_WIDTH-1:0] y, logic [QUAT_WIDTH-1:0] z,
                             logic [SCALE_WIDTH-1:0] s, logic [SHIFT_WIDTH-1:0] tx,
                             logic [SHIFT_WIDTH-1:0] ty, logic [SHIFT_WIDTH-1:0] tz);
        drain();
        write_reg(REG_ROT_W, CFG_DATA_WIDTH'(w));
        write_reg(REG_ROT_X, CFG_DATA_WIDTH'(x));
        write_reg(REG_ROT_Y, CFG_DATA_WIDTH'(y));
        write_reg(REG_ROT_Z, CFG_DATA_WIDTH'(z));
        write_reg(REG_SCALE, CFG_DATA_WIDTH'(s));
        write_reg(REG_SHIFT_X, tx);
        write_reg(REG_SHIFT_Y, ty);
        write_reg(REG_SHIFT_Z, tz);
        i_cfg_valid <= 0;
    endtask

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
            1: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
            2: return COORD_WIDTH'($signed($urandom_range(2000)) - 1000);
            default: return COORD_WIDTH'($urandom());
        endcase
    endfunction

    function automatic t_in_item rand_point();
        t_in_item p;
        p.point_x = rand_coord();
        p.point_y = rand_coord();
        p.point_z = rand_coord();
        return p;
    endfunction

    task automatic rand_calib();
        logic [QUAT_WIDTH-1:0] q[4];
        logic [SCALE_WIDTH-1:0] s;
        for (int i = 0; i < 4; i++) q[i] = QUAT_WIDTH'($urandom());
        case ($urandom_range(7))
            0: s = '0;
            1: s = '1;
            2: s = 20'd65536;
            default: s = SCALE_WIDTH'($urandom());
        endcase
        if ($urandom_range(9) == 0) q = '{'0, '0, '0, '0};
        set_calib(q[0], q[1], q[2], q[3], s, SHIFT_WIDTH'($urandom()),
                  SHIFT_WIDTH'($urandom()), SHIFT_WIDTH'($urandom()));
    endtask

    initial begin
        board = new();
        points_sent = 0;
        cfg_writes = 0;
        idle_pct = 9;
        start = 0;
        i_item = '0;
        i_cfg_valid = 0;
        i_cfg_index = REG_ROT_W;
        i_cfg_data = '0;
        i_rst_n = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;

        // reset calibration: pass-through
        send_point('{24'h7fffff, 24'h800000, 24'h000000});
        send_point('{24'hffffff, 24'h000001, 24'h123456});
        // identity at unit scale, shifted to the edges so sums saturate
        set_calib(18'd65536, '0, '0, '0, 20'd65536, 24'h7fffff, 24'h800000, 24'h000100);
        send_point('{24'h7fffff, 24'h800000, 24'h7fffff});
        send_point('{24'h000001, 24'hffffff, 24'h800000});
        send_point('{24'h000000, 24'h000000, 24'h000000});
        // extreme quaternion, largest scale
        set_calib(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000, '1, '0, '0, '0);
        send_point('{24'h7fffff, 24'h7fffff, 24'h800000});
        send_point('{24'h800000, 24'h000001, 24'hffffff});
        send_point('{24'h000080, 24'hffff80, 24'h000040});
        // 90 degrees about z, unnormalised, smallest scale
        set_calib(18'd1000, '0, '0, 18'd1000, 20'd1, 24'h000010, '0, 24'hfffff0);
        send_point('{24'h000300, 24'h7fffff, 24'h800000});
        send_point('{24'h000001, 24'h000001, 24'h000001});
        // zero norm: output is the shift
        set_calib('0, '0, '0, '0, 20'd65536, 24'h7fffff, 24'h800000, 24'h001234);
        send_point('{24'h7fffff, 24'h7fffff, 24'h7fffff});
        send_point('{24'h800000, 24'h000000, 24'h000001});
        // tiny quaternion, rounding ties
        set_calib(18'd1, 18'h3ffff, 18'd1, 18'h3ffff, 20'h8000, '0, '0, '0);
        send_point('{24'h000001, 24'hffffff, 24'h000003});
        send_point('{24'h555555, 24'haaaaaa, 24'h7fffff});

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 9 : (phase == 1) ? 73 : 0;
            for (int k = 0; k < 5; k++) begin
                rand_calib();
                repeat (27) send_point(rand_point());
            end
        end
        drain();

        $display("tb: %0d points checked over %0d register writes, pass-through, zero norm",
                 board.checked, cfg_writes);
        $display("tb: and saturation cases included, %0d points sent", points_sent);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: filelist.f
src/qst_pkg.sv
src/quaternion_similarity_transform.sv
src/qst_checker.sv
bench/quaternion_similarity_transform_tb.sv
